// ===== hdl/two_button_gesture_controller_top_assert.svh =====
// Assertion macros for the two-button gesture controller checker.
// Both macros sample on clk_i and are disabled while rst_ni is low.
`ifndef TWO_BUTTON_GESTURE_CONTROLLER_TOP_ASSERT_SVH
`define TWO_BUTTON_GESTURE_CONTROLLER_TOP_ASSERT_SVH

// Same-cycle implication.
`define TBGC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TBGC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/tbgc_pkg.sv =====
// ----------------------------------------------------------------------------
// tbgc_pkg
// Types, codes and reset values shared by the gesture controller files.
// ----------------------------------------------------------------------------
package tbgc_pkg;

  localparam int unsigned PAGE_COUNT = 3;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned MS_W    = 16;
  localparam int unsigned LEVEL_W = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [1:0] {
    KIND_POLL    = 2'd0,
    KIND_PRESS   = 2'd1,
    KIND_RELEASE = 2'd2
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EDGE_DEBOUNCE = 3'd0,
    CFG_LONG_PRESS    = 3'd1,
    CFG_ACTION_GAP    = 3'd2,
    CFG_LEVEL_ZERO    = 3'd3,
    CFG_LEVEL_ONE     = 3'd4,
    CFG_LEVEL_TWO     = 3'd5,
    CFG_LEVEL_THREE   = 3'd6
  } cfg_idx_e;

  localparam logic BTN_UPPER = 1'b0;
  localparam logic BTN_LOWER = 1'b1;

  localparam logic [MS_W-1:0]    EDGE_DEBOUNCE_RST = 16'd25;
  localparam logic [MS_W-1:0]    LONG_PRESS_RST    = 16'd850;
  localparam logic [MS_W-1:0]    ACTION_GAP_RST    = 16'd120;
  localparam logic [LEVEL_W-1:0] LEVEL_ZERO_RST    = 8'd40;
  localparam logic [LEVEL_W-1:0] LEVEL_ONE_RST     = 8'd96;
  localparam logic [LEVEL_W-1:0] LEVEL_TWO_RST     = 8'd160;
  localparam logic [LEVEL_W-1:0] LEVEL_THREE_RST   = 8'd255;
  localparam logic [1:0]         BRIGHT_RST        = 2'd3;

  typedef struct packed {
    logic [1:0]        kind;
    logic              button;
    logic [TIME_W-1:0] now_ms;
  } evt_t;

  typedef struct packed {
    logic [MS_W-1:0]              edge_debounce_ms;
    logic [MS_W-1:0]              long_press_ms;
    logic [MS_W-1:0]              action_gap_ms;
    logic [3:0][LEVEL_W-1:0]      levels;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         page;
    logic [1:0]         brightness_index;
    logic [LEVEL_W-1:0] backlight_level;
    logic               short_press;
    logic               edge_ignored;
    logic               upper_long_held;
    logic               lower_long_held;
  } result_t;

endpackage

// ===== hdl/tbgc_if.sv =====
// ----------------------------------------------------------------------------
// tbgc_if
// Valid/ready channels: button events, results and register writes.
// ----------------------------------------------------------------------------
interface tbgc_event_if;
  import tbgc_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic              button;
  logic [TIME_W-1:0] now_ms;
  modport source (output valid, kind, button, now_ms, input ready);
  modport sink   (input valid, kind, button, now_ms, output ready);
endinterface

interface tbgc_result_if;
  import tbgc_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         page;
  logic [1:0]         brightness_index;
  logic [LEVEL_W-1:0] backlight_level;
  logic               short_press;
  logic               edge_ignored;
  logic               upper_long_held;
  logic               lower_long_held;
  modport source (output valid, page, brightness_index, backlight_level, short_press,
                  edge_ignored, upper_long_held, lower_long_held, input ready);
  modport sink   (input valid, page, brightness_index, backlight_level, short_press,
                  edge_ignored, upper_long_held, lower_long_held, output ready);
endinterface

interface tbgc_cfg_if;
  import tbgc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/tbgc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// tbgc_cfg_regs
// Register file for timing thresholds and backlight levels.
// ----------------------------------------------------------------------------
module tbgc_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  tbgc_cfg_if.sink      cfg_i,
  output tbgc_pkg::cfg_t cfg_o
);
  import tbgc_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_EDGE_DEBOUNCE: cfg_d.edge_debounce_ms = cfg_i.data;
        CFG_LONG_PRESS:    cfg_d.long_press_ms    = cfg_i.data;
        CFG_ACTION_GAP:    cfg_d.action_gap_ms    = cfg_i.data;
        CFG_LEVEL_ZERO:    cfg_d.levels[0]        = cfg_i.data[LEVEL_W-1:0];
        CFG_LEVEL_ONE:     cfg_d.levels[1]        = cfg_i.data[LEVEL_W-1:0];
        CFG_LEVEL_TWO:     cfg_d.levels[2]        = cfg_i.data[LEVEL_W-1:0];
        CFG_LEVEL_THREE:   cfg_d.levels[3]        = cfg_i.data[LEVEL_W-1:0];
        default: ;  // unmapped index: dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.edge_debounce_ms <= EDGE_DEBOUNCE_RST;
      cfg_q.long_press_ms    <= LONG_PRESS_RST;
      cfg_q.action_gap_ms    <= ACTION_GAP_RST;
      cfg_q.levels[0]        <= LEVEL_ZERO_RST;
      cfg_q.levels[1]        <= LEVEL_ONE_RST;
      cfg_q.levels[2]        <= LEVEL_TWO_RST;
      cfg_q.levels[3]        <= LEVEL_THREE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/tbgc_core.sv =====
// ----------------------------------------------------------------------------
// tbgc_core
// Per-button debounce, press timing and short-press actions; one event a cycle while en_i is high.
// ----------------------------------------------------------------------------
module tbgc_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  tbgc_pkg::evt_t    evt_i,
  input  tbgc_pkg::cfg_t    cfg_i,
  output tbgc_pkg::result_t result_o
);
  import tbgc_pkg::*;

  logic [TIME_W-1:0] last_edge_q [2], last_edge_d [2];
  logic [TIME_W-1:0] start_q     [2], start_d     [2];
  logic [TIME_W-1:0] last_act_q  [2], last_act_d  [2];
  logic [1:0]        held_q, held_d;
  logic [1:0]        long_q, long_d;
  logic [1:0]        page_q, page_d;
  logic [1:0]        bright_q, bright_d;

  logic [1:0]        short_hit;
  logic [1:0]        ignored_hit;
  logic              is_edge;
  logic [TIME_W-1:0] lp_ext, deb_ext, gap_ext;
  logic [1:0]        page_inc;

  assign is_edge = (evt_i.kind == KIND_PRESS) || (evt_i.kind == KIND_RELEASE);
  assign lp_ext  = {{(TIME_W-MS_W){1'b0}}, cfg_i.long_press_ms};
  assign deb_ext = {{(TIME_W-MS_W){1'b0}}, cfg_i.edge_debounce_ms};
  assign gap_ext = {{(TIME_W-MS_W){1'b0}}, cfg_i.action_gap_ms};

  always_comb begin
    logic              hit, bounce, acc, press, rel;
    logic [TIME_W-1:0] since_edge, since_start, since_act, since_new_start;
    logic              long_tmp;
    for (int i = 0; i < 2; i++) begin
      hit         = is_edge && (evt_i.button == 1'(i));
      since_edge  = evt_i.now_ms - last_edge_q[i];
      since_start = evt_i.now_ms - start_q[i];
      since_act   = evt_i.now_ms - last_act_q[i];
      bounce      = since_edge < deb_ext;
      acc         = hit && !bounce;
      press       = acc && (evt_i.kind == KIND_PRESS);
      rel         = acc && (evt_i.kind == KIND_RELEASE);

      ignored_hit[i] = hit && bounce;
      short_hit[i]   = rel && held_q[i] && !long_q[i] &&
                       (since_start < lp_ext) && (since_act >= gap_ext);

      last_edge_d[i] = acc ? evt_i.now_ms : last_edge_q[i];
      start_d[i]     = press ? evt_i.now_ms : start_q[i];
      last_act_d[i]  = short_hit[i] ? evt_i.now_ms : last_act_q[i];
      held_d[i]      = press ? 1'b1 : (rel ? 1'b0 : held_q[i]);

      // long check runs on the post-edge state of every button
      long_tmp        = (press || rel) ? 1'b0 : long_q[i];
      since_new_start = evt_i.now_ms - start_d[i];
      long_d[i]       = long_tmp || (held_d[i] && (since_new_start >= lp_ext));
    end
  end

  assign page_inc = page_q + 2'd1;

  always_comb begin
    page_d   = page_q;
    bright_d = bright_q;
    if (short_hit[BTN_UPPER]) begin
      page_d = (32'(page_inc) == PAGE_COUNT) ? 2'd0 : page_inc;
    end
    if (short_hit[BTN_LOWER]) begin
      bright_d = bright_q - 2'd1;  // 0 wraps to 3
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 2; i++) begin
        last_edge_q[i] <= '0;
        start_q[i]     <= '0;
        last_act_q[i]  <= '0;
      end
      held_q   <= '0;
      long_q   <= '0;
      page_q   <= '0;
      bright_q <= BRIGHT_RST;
    end else if (en_i) begin
      for (int i = 0; i < 2; i++) begin
        last_edge_q[i] <= last_edge_d[i];
        start_q[i]     <= start_d[i];
        last_act_q[i]  <= last_act_d[i];
      end
      held_q   <= held_d;
      long_q   <= long_d;
      page_q   <= page_d;
      bright_q <= bright_d;
    end
  end

  always_comb begin
    result_o.page             = page_d;
    result_o.brightness_index = bright_d;
    result_o.backlight_level  = cfg_i.levels[bright_d];
    result_o.short_press      = |short_hit;
    result_o.edge_ignored     = |ignored_hit;
    result_o.upper_long_held  = long_d[BTN_UPPER];
    result_o.lower_long_held  = long_d[BTN_LOWER];
  end

endmodule

// ===== hdl/tbgc_out_reg.sv =====
// ----------------------------------------------------------------------------
// tbgc_out_reg
// Result register driving the output channel.
// ----------------------------------------------------------------------------
module tbgc_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  tbgc_pkg::result_t result_i,
  output logic              free_o,
  tbgc_result_if.source     res_o
);
  import tbgc_pkg::*;

  logic    valid_q, valid_d;
  result_t data_q;

  assign free_o  = !valid_q || res_o.ready;
  assign valid_d = load_i ? 1'b1 : (res_o.ready ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

  assign res_o.valid            = valid_q;
  assign res_o.page             = data_q.page;
  assign res_o.brightness_index = data_q.brightness_index;
  assign res_o.backlight_level  = data_q.backlight_level;
  assign res_o.short_press      = data_q.short_press;
  assign res_o.edge_ignored     = data_q.edge_ignored;
  assign res_o.upper_long_held  = data_q.upper_long_held;
  assign res_o.lower_long_held  = data_q.lower_long_held;

endmodule

// ===== hdl/two_button_gesture_controller_top.sv =====
// ----------------------------------------------------------------------------
// two_button_gesture_controller_top
// Debounced page/brightness control from two buttons with long-press lockout.
// ----------------------------------------------------------------------------
// Takes one beat per cycle on evt_i (press edge, release edge or time poll,
// stamped in ms) while res_o is not stalled and returns exactly one result
// beat per event on res_o, in order, via the input and result registers.
// The per-button state (edge, press and action times, held/long marks, page,
// brightness) is updated from the registered event as its result is loaded,
// so each event sees the state left by the one before. Register writes on
// cfg_i are always taken; write only while no event is in flight. No
// clearing pass after reset: all state is in flip-flops.
module two_button_gesture_controller_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  tbgc_event_if.sink    evt_i,
  tbgc_cfg_if.sink      cfg_i,
  tbgc_result_if.source res_o
);
  import tbgc_pkg::*;

  // input register
  logic    in_valid_q;
  evt_t    evt_q;

  cfg_t    cfg;
  result_t result;
  logic    out_free;
  logic    step;

  // an event moves on when the result register can take it
  assign step        = in_valid_q && out_free;
  assign evt_i.ready = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (evt_i.ready) begin
      in_valid_q <= evt_i.valid;
    end
  end

  // payload: no reset needed
  always_ff @(posedge clk_i) begin
    if (evt_i.valid && evt_i.ready) begin
      evt_q.kind   <= evt_i.kind;
      evt_q.button <= evt_i.button;
      evt_q.now_ms <= evt_i.now_ms;
    end
  end

  tbgc_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // state update and result in one pass
  tbgc_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (step),
    .evt_i    (evt_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  tbgc_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (step),
    .result_i (result),
    .free_o   (out_free),
    .res_o    (res_o)
  );

endmodule

// ===== hdl/tbgc_checker.sv =====
// ----------------------------------------------------------------------------
// tbgc_checker
// Port-level checks for the gesture controller, bound to the top level.
// ----------------------------------------------------------------------------
`include "two_button_gesture_controller_top_assert.svh"

module tbgc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [1:0] page_i,
  input logic [1:0] bright_i,
  input logic [7:0] level_i,
  input logic       short_i,
  input logic       ignored_i
);

  logic        in_beat;
  logic        out_beat;
  logic        out_stall;
  logic        quiet;
  logic [3:0]  knobs;
  logic [13:0] shown;

  assign in_beat   = in_valid_i && in_ready_i;
  assign out_beat  = out_valid_i && out_ready_i;
  assign out_stall = out_valid_i && !out_ready_i;
  assign quiet     = out_valid_i && !short_i;
  assign knobs     = {page_i, bright_i};
  assign shown     = {page_i, bright_i, level_i, short_i, ignored_i};

  // stalled result holds
  `TBGC_ASSERT_NEXT(a_out_hold, out_stall, out_valid_i && $stable(shown), "stalled beat changed")

  // with the output side empty, input is never back-pressured
  `TBGC_ASSERT_IMPL(a_in_ready, !out_valid_i, in_ready_i, "input stalled with empty output")

  // an accepted event shows a valid result beat once it has passed the input and result registers
  `TBGC_ASSERT_NEXT(a_in_to_out, in_beat, ##1 out_valid_i, "accepted event gave no result")

  // page and brightness only move on a short press
  `TBGC_ASSERT_IMPL(a_no_silent_change, out_beat ##1 quiet, knobs == $past(knobs), "no short press")

  // a dropped edge never also acts
  `TBGC_ASSERT_IMPL(a_ignore_excl, out_valid_i && ignored_i, !short_i, "ignored edge gave action")

endmodule

bind two_button_gesture_controller_top tbgc_checker u_tbgc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (evt_i.valid),
  .in_ready_i  (evt_i.ready),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .page_i      (res_o.page),
  .bright_i    (res_o.brightness_index),
  .level_i     (res_o.backlight_level),
  .short_i     (res_o.short_press),
  .ignored_i   (res_o.edge_ignored)
);
